// ===== src/indexed_insert_delete_array_defines.svh =====
// Assertion macros used by the array list top level.
`ifndef INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define IIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define IIDA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/iida_pkg.sv =====
// Shared codes and constants for the indexed insert/delete array list.
package iida_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] LimitReset = 5'd16;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_EDIT   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

// ===== src/iida_ctrl.sv =====
// Handshake controller: tracks the output slot and issues the execute strobe.
module iida_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic m_ready_i,
  output logic s_ready_o,
  output logic m_valid_o,
  output logic exec_o
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_e;

  state_e state_q;

  // Take a new beat when the slot is free or is being emptied this cycle.
  assign s_ready_o = (state_q == S_IDLE) || m_ready_i;
  assign exec_o    = s_valid_i && s_ready_o;
  assign m_valid_o = (state_q == S_RESULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (exec_o) state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (m_ready_i && !exec_o) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/iida_dpath.sv =====
// Datapath: entry registers with shift network, count, limit and result registers.
module iida_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         exec_i,
  input  iida_pkg::cmd_e               cmd_i,
  input  logic [iida_pkg::PosW-1:0]    pos_i,
  input  logic [iida_pkg::WordW-1:0]   word_i,
  input  logic                         cfg_we_i,
  input  logic [iida_pkg::CountW-1:0]  cfg_wdata_i,
  output iida_pkg::status_e            status_o,
  output logic [iida_pkg::WordW-1:0]   word_o,
  output logic [iida_pkg::CountW-1:0]  count_o
);
  import iida_pkg::*;

  // Only the first entries are reachable by a read position.
  localparam int RdN = (DEPTH < (1 << PosW)) ? DEPTH : (1 << PosW);

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] limit_q;
  logic [WordW-1:0]  entry_q [DEPTH];
  logic [WordW-1:0]  entry_d [DEPTH];
  logic [WordW-1:0]  prev_w  [DEPTH];
  logic [WordW-1:0]  next_w  [DEPTH];
  status_e           status_d, status_q;
  logic [WordW-1:0]  rd_sel, rd_d, word_q;
  logic [CountW-1:0] pos_ext;
  logic              full, do_ins, do_edit, do_rem;

  assign pos_ext = {1'b0, pos_i};
  assign full    = (count_q >= limit_q) || ({27'b0, count_q} >= 32'(DEPTH));

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RdN; i++) begin
      if (int'(pos_i) == i) rd_sel = entry_q[i];
    end
  end

  always_comb begin
    status_d = ST_DONE;
    rd_d     = '0;
    do_ins   = 1'b0;
    do_edit  = 1'b0;
    do_rem   = 1'b0;
    count_d  = count_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_ext > count_q) begin
          status_d = ST_RANGE;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      default: begin
        if (pos_ext >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          case (cmd_i)
            CMD_READ:   rd_d = rd_sel;
            CMD_EDIT:   do_edit = 1'b1;
            CMD_REMOVE: begin
              do_rem  = 1'b1;
              count_d = count_q - 1'b1;
            end
            default:    rd_d = '0;
          endcase
        end
      end
    endcase
  end

  // Neighbour taps; the end entries see themselves or zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    if (g == 0) begin : g_first
      assign prev_w[g] = '0;
    end else begin : g_prev
      assign prev_w[g] = entry_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w[g] = entry_q[g];
    end else begin : g_next
      assign next_w[g] = entry_q[g+1];
    end

    always_comb begin
      entry_d[g] = entry_q[g];
      if (do_ins) begin
        if (g == int'(pos_i))     entry_d[g] = word_i;
        else if (g > int'(pos_i)) entry_d[g] = prev_w[g];
      end else if (do_edit) begin
        if (g == int'(pos_i))     entry_d[g] = word_i;
      end else if (do_rem) begin
        if (g >= int'(pos_i))     entry_d[g] = next_w[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (exec_i) entry_q[g] <= entry_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LimitReset;
    end else begin
      if (exec_i)   count_q <= count_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      status_q <= status_d;
      word_q   <= rd_d;
    end
  end

  assign status_o = status_q;
  assign word_o   = word_q;
  assign count_o  = count_q;

endmodule

// ===== src/indexed_insert_delete_array.sv =====
// Array list of signed words with indexed read, insert, overwrite and remove.
// Result: a result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the consumer takes each result; every entry has its own register, so a
//   shift across all later entries completes in the accepting cycle.
// Reset: count cleared, capacity limit set to 16, entry registers not cleared.
module indexed_insert_delete_array #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [3:0] position, [35:4] word_in, [39:36] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  // Result beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] word_out, [36:32] item_count, [39:37] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  // Capacity limit register
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import iida_pkg::*;
  `include "indexed_insert_delete_array_defines.svh"

  logic              exec;
  status_e           status;
  logic [WordW-1:0]  word_out;
  logic [CountW-1:0] item_count;
  cmd_e              cmd;
  logic              in_beat;
  logic              refused;
  logic              count_ok;

  // Decode the operation selector from the sideband.
  assign cmd = cmd_e'(s_axis_tuser);

  // Controller: hold the result slot, advance when the consumer takes the beat.
  iida_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .exec_o    (exec)
  );

  // Datapath: decide status, shift entries and register the result.
  iida_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (exec),
    .cmd_i       (cmd),
    .pos_i       (s_axis_tdata[PosW-1:0]),
    .word_i      (s_axis_tdata[PosW+WordW-1:PosW]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .word_o      (word_out),
    .count_o     (item_count)
  );

  // Pack the result: data word low, count above, pad with zeros.
  assign m_axis_tdata = {3'b000, item_count, word_out};
  assign m_axis_tuser = status;

  // Terms for the checks below.
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign refused  = m_axis_tvalid && (status != ST_DONE);
  assign count_ok = ({27'b0, item_count} <= 32'(DEPTH));

  // An accepted beat always produces a pending result next cycle.
  `IIDA_ASSERT_NEXT(a_accept_gives_result, in_beat, m_axis_tvalid, "accepted beat gave no result")
  // With no result pending the block must take input.
  `IIDA_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "not ready when empty")
  // A refused step carries a zero data word.
  `IIDA_ASSERT(a_refused_zero, refused |-> (word_out == '0), "refused step returned data")
  // The count never exceeds the storage depth.
  `IIDA_ASSERT(a_count_bound, m_axis_tvalid |-> count_ok, "count above depth")

endmodule
